// ===== rtl/ccfc_pkg.sv =====
package ccfc_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int LEN_W       = 8;
  localparam int OP_W        = 2;

  localparam logic [LEN_W-1:0] BUDGET_RESET = LEN_W'(127);
  localparam logic [LEN_W-1:0] TERM_BYTES   = LEN_W'(2);

  typedef enum logic [OP_W-1:0] {
    OP_SEND = 2'd0,
    OP_OK   = 2'd1,
    OP_ERR  = 2'd2
  } op_t;

  typedef struct packed {
    logic               accepted;
    logic               feed_hold;
    logic               reply_underflow;
    logic [LEN_W-1:0]   bytes_in_flight;
    logic [COUNT_W-1:0] lines_in_flight;
    logic               halted;
  } result_t;

endpackage

// ===== rtl/ccfc_ram.sv =====
module ccfc_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/ccfc_ctrl.sv =====
module ccfc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [ccfc_pkg::OP_W-1:0]       operation,
  input  logic [ccfc_pkg::LEN_W-1:0]      text_length,
  input  logic [ccfc_pkg::LEN_W-1:0]      budget,
  input  logic                            out_free,
  output logic                            commit,
  output ccfc_pkg::result_t               result,
  output logic                            mem_wr_en,
  output logic [ccfc_pkg::PTR_W-1:0]      mem_wr_addr,
  output logic [ccfc_pkg::LEN_W-1:0]      mem_wr_data,
  output logic [ccfc_pkg::PTR_W-1:0]      mem_rd_addr,
  input  logic [ccfc_pkg::LEN_W-1:0]      mem_rd_data
);

  localparam int TAIL_W = ccfc_pkg::COUNT_W + 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_t;

  state_t state, state_next;

  logic [ccfc_pkg::OP_W-1:0]    op_q;
  logic [ccfc_pkg::LEN_W-1:0]   text_q;
  logic [ccfc_pkg::PTR_W-1:0]   head, head_next;
  logic [ccfc_pkg::COUNT_W-1:0] count, count_next;
  logic [ccfc_pkg::LEN_W-1:0]   total, total_next;
  logic                         halt, halt_next;

  logic [ccfc_pkg::LEN_W:0]     line;
  logic [ccfc_pkg::LEN_W+1:0]   sum;
  logic [TAIL_W-1:0]            tail_raw;
  logic [TAIL_W-1:0]            tail_wrap;
  logic                         fits;
  logic                         not_full;
  logic                         admit;
  logic                         pop;

  assign in_ready = (state == ST_IDLE);
  assign commit   = (state == ST_LOOK) && out_free;

  // head is read every cycle; the LOOK state covers the read latency
  assign mem_rd_addr = head;

  always_comb begin
    line      = {1'b0, text_q} + {1'b0, ccfc_pkg::TERM_BYTES};
    sum       = {2'b00, total} + {1'b0, line};
    fits      = sum <= {2'b00, budget};
    not_full  = count < ccfc_pkg::COUNT_W'(ccfc_pkg::QUEUE_DEPTH);
    tail_raw  = TAIL_W'(head) + TAIL_W'(count);
    tail_wrap = (tail_raw >= TAIL_W'(ccfc_pkg::QUEUE_DEPTH))
              ? tail_raw - TAIL_W'(ccfc_pkg::QUEUE_DEPTH) : tail_raw;
    admit     = 1'b0;
    pop       = 1'b0;
    halt_next = halt;
    result    = '0;
    case (op_q)
      ccfc_pkg::OP_SEND: begin
        admit = !halt && not_full && fits;
      end
      ccfc_pkg::OP_OK: begin
        pop                    = (count != '0);
        result.reply_underflow = (count == '0);
      end
      ccfc_pkg::OP_ERR: begin
        pop                    = (count != '0);
        result.reply_underflow = (count == '0);
        result.feed_hold       = 1'b1;
        halt_next              = 1'b1;
      end
      default: begin
      end
    endcase

    head_next  = head;
    count_next = count;
    total_next = total;
    if (admit) begin
      count_next = count + 1'b1;
      total_next = sum[ccfc_pkg::LEN_W-1:0];
    end else if (pop) begin
      count_next = count - 1'b1;
      total_next = total - mem_rd_data;
      head_next  = (head == ccfc_pkg::PTR_W'(ccfc_pkg::QUEUE_DEPTH - 1))
                 ? '0 : head + 1'b1;
    end

    result.accepted        = admit;
    result.bytes_in_flight = total_next;
    result.lines_in_flight = count_next;
    result.halted          = halt_next;

    mem_wr_en   = commit && admit;
    mem_wr_addr = tail_wrap[ccfc_pkg::PTR_W-1:0];
    mem_wr_data = line[ccfc_pkg::LEN_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_LOOK;
      ST_LOOK: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      count <= '0;
      total <= '0;
      halt  <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        head  <= head_next;
        count <= count_next;
        total <= total_next;
        halt  <= halt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= operation;
      text_q <= text_length;
    end
  end

endmodule

// ===== rtl/char_count_flow_control.sv =====
// channel  | handshake             | payload
// in       | in_valid / in_ready   | operation, text_length
// out      | out_valid / out_ready | accepted, feed_hold, reply_underflow,
//          |                       | bytes_in_flight, lines_in_flight, halted
// cfg      | cfg_valid / cfg_ready | byte_budget
//
// Each item passes through the IDLE and LOOK states: IDLE accepts it while
// the head entry of the length memory is read, and LOOK updates state and
// loads the output register. No new item is accepted until the last commits.
// A full output register holds the update until the result beat is taken.
// Synchronous reset empties the queue and clears halt; budget returns to 127.
module char_count_flow_control (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ccfc_pkg::OP_W-1:0]         operation,
  input  logic [ccfc_pkg::LEN_W-1:0]        text_length,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              accepted,
  output logic                              feed_hold,
  output logic                              reply_underflow,
  output logic [ccfc_pkg::LEN_W-1:0]        bytes_in_flight,
  output logic [ccfc_pkg::COUNT_W-1:0]      lines_in_flight,
  output logic                              halted,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ccfc_pkg::LEN_W-1:0]        byte_budget
);

  logic [ccfc_pkg::LEN_W-1:0] budget;
  logic                       out_free;
  logic                       commit;
  ccfc_pkg::result_t          result;
  ccfc_pkg::result_t          out_q;

  logic                       mem_wr_en;
  logic [ccfc_pkg::PTR_W-1:0] mem_wr_addr;
  logic [ccfc_pkg::LEN_W-1:0] mem_wr_data;
  logic [ccfc_pkg::PTR_W-1:0] mem_rd_addr;
  logic [ccfc_pkg::LEN_W-1:0] mem_rd_data;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= ccfc_pkg::BUDGET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      budget <= byte_budget;
    end
  end

  ccfc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .text_length (text_length),
    .budget      (budget),
    .out_free    (out_free),
    .commit      (commit),
    .result      (result),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ccfc_ram #(
    .DEPTH  (ccfc_pkg::QUEUE_DEPTH),
    .WIDTH  (ccfc_pkg::LEN_W),
    .ADDR_W (ccfc_pkg::PTR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_q <= result;
    end
  end

  assign accepted        = out_q.accepted;
  assign feed_hold       = out_q.feed_hold;
  assign reply_underflow = out_q.reply_underflow;
  assign bytes_in_flight = out_q.bytes_in_flight;
  assign lines_in_flight = out_q.lines_in_flight;
  assign halted          = out_q.halted;

endmodule

// ===== rtl/ccfc_checker.sv =====
module ccfc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         accepted,
  input logic                         feed_hold,
  input logic [ccfc_pkg::LEN_W-1:0]   bytes_in_flight,
  input logic [ccfc_pkg::COUNT_W-1:0] lines_in_flight,
  input logic                         halted
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(bytes_in_flight)
      && $stable(lines_in_flight) && $stable(halted))
    else $error("result beat changed while stalled");

  a_accept_not_halted: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> !halted && lines_in_flight != '0)
    else $error("line admitted while halted or queue empty");

  a_hold_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && feed_hold |-> halted)
    else $error("feed hold without halt");

  a_empty_no_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && lines_in_flight == '0 |-> bytes_in_flight == '0)
    else $error("bytes outstanding with no lines");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> lines_in_flight <= ccfc_pkg::COUNT_W'(ccfc_pkg::QUEUE_DEPTH))
    else $error("line count beyond queue depth");

endmodule

bind char_count_flow_control ccfc_checker u_ccfc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .accepted        (accepted),
  .feed_hold       (feed_hold),
  .bytes_in_flight (bytes_in_flight),
  .lines_in_flight (lines_in_flight),
  .halted          (halted)
);

// ===== bench/char_count_flow_control_tb.sv =====
module char_count_flow_control_tb;

  localparam logic [ccfc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int PRE_ROWS      = 13;
  localparam int ROWS          = 19;
  localparam int PHASES        = 10;
  localparam int PHASE_LINES   = 110;
  localparam int TAIL_LINES    = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [ccfc_pkg::OP_W-1:0]  op;
    logic [ccfc_pkg::LEN_W-1:0] len;
    logic                       typed;
    ccfc_pkg::result_t          want;
  } line_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [ccfc_pkg::OP_W-1:0]    operation = '0;
  logic [ccfc_pkg::LEN_W-1:0]   text_length = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         accepted;
  logic                         feed_hold;
  logic                         reply_underflow;
  logic [ccfc_pkg::LEN_W-1:0]   bytes_in_flight;
  logic [ccfc_pkg::COUNT_W-1:0] lines_in_flight;
  logic                         halted;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [ccfc_pkg::LEN_W-1:0]   byte_budget = '0;

  // credit tracker state
  logic [ccfc_pkg::LEN_W-1:0] line_ring [ccfc_pkg::QUEUE_DEPTH];
  int                         oldest_slot = 0;
  int                         inflight_lines = 0;
  int                         inflight_bytes = 0;
  logic                       halt_seen = 1'b0;
  logic [ccfc_pkg::LEN_W-1:0] budget_now = ccfc_pkg::BUDGET_RESET;

  ccfc_pkg::result_t pending_status [$];
  int                mismatches = 0;
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;

  // Error replies halt the block until reset, so the rows from PRE_ROWS on
  // are walked only after the random phases.
  line_row_t directed_rows [ROWS] = '{
    '{ccfc_pkg::OP_OK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b1, 8'd0,   7'd0, 1'b0}},
    '{OP_UNUSED,         8'd255, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd0,   7'd0, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd0,   1'b1, '{1'b1, 1'b0, 1'b0, 8'd2,   7'd1, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd253, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd2,   7'd1, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd255, 1'b1, '{1'b0, 1'b0, 1'b0, 8'd2,   7'd1, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd123, 1'b1, '{1'b1, 1'b0, 1'b0, 8'd127, 7'd2, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd127, 7'd2, 1'b0}},
    '{ccfc_pkg::OP_OK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd125, 7'd1, 1'b0}},
    '{ccfc_pkg::OP_OK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0,   7'd0, 1'b0}},
    '{ccfc_pkg::OP_OK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b1, 8'd0,   7'd0, 1'b0}},
    '{ccfc_pkg::OP_SEND, 8'd170, 1'b0, '0},
    '{ccfc_pkg::OP_SEND, 8'ha5,  1'b0, '0},
    '{ccfc_pkg::OP_OK,   8'h5a,  1'b0, '0},
    // budget back at 127, nothing outstanding
    '{ccfc_pkg::OP_SEND, 8'd5,   1'b1, '{1'b1, 1'b0, 1'b0, 8'd7,   7'd1, 1'b0}},
    '{ccfc_pkg::OP_ERR,  8'd0,   1'b1, '{1'b0, 1'b1, 1'b0, 8'd0,   7'd0, 1'b1}},
    '{ccfc_pkg::OP_ERR,  8'd255, 1'b1, '{1'b0, 1'b1, 1'b1, 8'd0,   7'd0, 1'b1}},
    '{ccfc_pkg::OP_SEND, 8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0,   7'd0, 1'b1}},
    '{ccfc_pkg::OP_OK,   8'd0,   1'b1, '{1'b0, 1'b0, 1'b1, 8'd0,   7'd0, 1'b1}},
    '{OP_UNUSED,         8'd0,   1'b1, '{1'b0, 1'b0, 1'b0, 8'd0,   7'd0, 1'b1}}
  };

  char_count_flow_control u_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .text_length     (text_length),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .accepted        (accepted),
    .feed_hold       (feed_hold),
    .reply_underflow (reply_underflow),
    .bytes_in_flight (bytes_in_flight),
    .lines_in_flight (lines_in_flight),
    .halted          (halted),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .byte_budget     (byte_budget)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic ccfc_pkg::result_t track_credit(logic [ccfc_pkg::OP_W-1:0] op,
                                                     logic [ccfc_pkg::LEN_W-1:0] len);
    ccfc_pkg::result_t r;
    int                line_bytes;
    r = '0;
    // widen first: 254 and 255 must not wrap after adding CR/LF
    line_bytes = int'(len) + int'(ccfc_pkg::TERM_BYTES);
    if (op == ccfc_pkg::OP_SEND) begin
      if (!halt_seen && inflight_lines < ccfc_pkg::QUEUE_DEPTH &&
          inflight_bytes + line_bytes <= int'(budget_now)) begin
        line_ring[(oldest_slot + inflight_lines) % ccfc_pkg::QUEUE_DEPTH] =
          ccfc_pkg::LEN_W'(line_bytes);
        inflight_lines++;
        inflight_bytes += line_bytes;
        r.accepted = 1'b1;
      end
    end else if (op == ccfc_pkg::OP_OK || op == ccfc_pkg::OP_ERR) begin
      if (inflight_lines == 0) begin
        r.reply_underflow = 1'b1;
      end else begin
        inflight_bytes -= int'(line_ring[oldest_slot]);
        oldest_slot = (oldest_slot + 1) % ccfc_pkg::QUEUE_DEPTH;
        inflight_lines--;
      end
      if (op == ccfc_pkg::OP_ERR) begin
        r.feed_hold = 1'b1;
        halt_seen = 1'b1;
      end
    end
    r.bytes_in_flight = ccfc_pkg::LEN_W'(inflight_bytes);
    r.lines_in_flight = ccfc_pkg::COUNT_W'(inflight_lines);
    r.halted = halt_seen;
    return r;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_line(logic [ccfc_pkg::OP_W-1:0] op, logic [ccfc_pkg::LEN_W-1:0] len,
                           logic typed, ccfc_pkg::result_t want);
    int                gap;
    ccfc_pkg::result_t predicted;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    text_length <= len;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = track_credit(op, len);
    pending_status.push_back(typed ? want : predicted);
  endtask

  task automatic random_line(int send_pct, int err_pct, int len_hi);
    int                        r;
    logic [ccfc_pkg::OP_W-1:0] op;
    r = $urandom_range(0, 99);
    if (r < send_pct) op = ccfc_pkg::OP_SEND;
    else if (r < send_pct + err_pct) op = ccfc_pkg::OP_ERR;
    else if (r < 95) op = ccfc_pkg::OP_OK;
    else op = OP_UNUSED;
    send_line(op, ccfc_pkg::LEN_W'($urandom_range(0, len_hi)), 1'b0, '0);
  endtask

  // only once every outstanding beat has come back
  task automatic set_budget(logic [ccfc_pkg::LEN_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    byte_budget <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    budget_now = value;
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = quiet ? 0 : pick_gap();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    ccfc_pkg::result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_status.size() == 0) begin
        $error("result beat with no status expected");
        mismatches++;
      end else begin
        want = pending_status.pop_front();
        check_field("accepted", 8'(want.accepted), 8'(accepted));
        check_field("feed_hold", 8'(want.feed_hold), 8'(feed_hold));
        check_field("reply_underflow", 8'(want.reply_underflow), 8'(reply_underflow));
        check_field("bytes_in_flight", want.bytes_in_flight, bytes_in_flight);
        check_field("lines_in_flight", 8'(want.lines_in_flight), 8'(lines_in_flight));
        check_field("halted", 8'(want.halted), 8'(halted));
      end
    end
  end

  initial begin
    int i;
    int p;
    int budget;
    int len_hi;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < PRE_ROWS; i++)
      send_line(directed_rows[i].op, directed_rows[i].len, directed_rows[i].typed,
                directed_rows[i].want);

    // phase 0 fills the queue; phase 1 then drops the budget under the bytes in flight
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0, 5:    budget = 255;
        1:       budget = 1;
        2:       budget = 2;
        default: budget = $urandom_range(1, 255);
      endcase
      set_budget(ccfc_pkg::LEN_W'(budget));
      quiet = (p == 3 || p == 7);
      if (p == 4) hold_req = 1'b1;
      len_hi = (p % 3 == 0) ? 3 : (p % 3 == 1) ? 60 : 255;
      repeat (PHASE_LINES) random_line((p % 2 == 0) ? 70 : 45, 0, len_hi);
    end

    quiet = 1'b0;
    while (inflight_lines != 0)
      send_line(ccfc_pkg::OP_OK, ccfc_pkg::LEN_W'($urandom_range(0, 255)), 1'b0, '0);
    set_budget(ccfc_pkg::BUDGET_RESET);

    for (i = PRE_ROWS; i < ROWS; i++)
      send_line(directed_rows[i].op, directed_rows[i].len, directed_rows[i].typed,
                directed_rows[i].want);
    repeat (TAIL_LINES) random_line(35, 25, 255);

    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
